// ===== rtl/core/stt_pkg.sv =====
`timescale 1ns / 1ps

package stt_pkg;

    localparam int NUM_TIMERS  = 8;
    localparam int IDX_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int MAX_RESULTS = 8;
    localparam int FOUND_W     = $clog2(MAX_RESULTS + 1);

    localparam int REQ_W  = 2;
    localparam int KIND_W = 3;
    localparam int SLOT_W = 3;
    localparam int WORD_W = 32;

    localparam int S_FIELDS_W = 3 * WORD_W + SLOT_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = SLOT_W + 2 * WORD_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [REQ_W-1:0] REQ_CREATE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;

    localparam logic [KIND_W-1:0] KIND_CREATED    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FAILED     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DELETED    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EXPIRED    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NO_EXPIRY  = 3'd4;

    typedef enum logic [2:0] {
        PUSH_CREATED,
        PUSH_FAILED,
        PUSH_DELETED,
        PUSH_EXPIRED,
        PUSH_NO_EXPIRY
    } push_sel_t;

    typedef struct packed {
        logic             latch;
        logic             tick_inc;
        logic             create_wr;
        logic             del_clr;
        logic             exp_clr;
        logic             pend_load;
        logic             push;
        push_sel_t        push_sel;
        logic             push_last;
        logic [IDX_W-1:0] idx;
    } stt_cmd_t;

    typedef struct packed {
        logic out_free;
        logic create_bad;
        logic idx_used;
        logic due;
    } stt_status_t;

endpackage

// ===== rtl/core/stt_ctrl.sv =====
`timescale 1ns / 1ps

module stt_ctrl
    import stt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [REQ_W-1:0]  in_req,
    output logic              in_ready,
    input  stt_status_t       status,
    output stt_cmd_t          cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CREATE,
        ST_DELETE,
        ST_TICK_RD,
        ST_TICK_CHK,
        ST_FINISH
    } state_t;

    localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(NUM_TIMERS - 1);
    localparam logic [FOUND_W-1:0] FOUND_MAX = FOUND_W'(MAX_RESULTS);

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [FOUND_W-1:0] found_reg, found_next;
    logic [FOUND_W-1:0] found_inc;

    assign in_ready  = (state_reg == ST_IDLE);
    assign found_inc = found_reg + FOUND_W'(1);

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        found_next    = found_reg;
        cmd           = '0;
        cmd.push_sel  = PUSH_FAILED;
        cmd.push_last = 1'b1;
        cmd.idx       = idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    idx_next  = '0;
                    found_next = '0;
                    if (in_req == REQ_CREATE)
                    begin
                        state_next = ST_CREATE;
                    end
                    else if (in_req == REQ_DELETE)
                    begin
                        state_next = ST_DELETE;
                    end
                    else if (in_req == REQ_TICK)
                    begin
                        cmd.tick_inc = 1'b1;
                        state_next   = ST_TICK_RD;
                    end
                end
            end

            ST_CREATE:
            begin
                if (status.create_bad || !status.idx_used || idx_reg == LAST_IDX)
                begin
                    if (status.out_free)
                    begin
                        cmd.push = 1'b1;
                        if (!status.create_bad && !status.idx_used)
                        begin
                            cmd.create_wr = 1'b1;
                            cmd.push_sel  = PUSH_CREATED;
                        end
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            ST_DELETE:
            begin
                if (status.out_free)
                begin
                    cmd.del_clr  = 1'b1;
                    cmd.push     = 1'b1;
                    cmd.push_sel = PUSH_DELETED;
                    state_next   = ST_IDLE;
                end
            end

            ST_TICK_RD:
            begin
                state_next = ST_TICK_CHK;
            end

            ST_TICK_CHK:
            begin
                if (status.due)
                begin
                    if (found_reg == '0 || status.out_free)
                    begin
                        // hand the held expiry on, hold the new one until the next is known
                        cmd.push      = (found_reg != '0);
                        cmd.push_sel  = PUSH_EXPIRED;
                        cmd.push_last = 1'b0;
                        cmd.pend_load = 1'b1;
                        cmd.exp_clr   = 1'b1;
                        found_next    = found_inc;
                        if (found_inc == FOUND_MAX || idx_reg == LAST_IDX)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            idx_next   = idx_reg + IDX_W'(1);
                            state_next = ST_TICK_RD;
                        end
                    end
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_TICK_RD;
                end
            end

            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.push     = 1'b1;
                    cmd.push_sel = (found_reg != '0) ? PUSH_EXPIRED : PUSH_NO_EXPIRY;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            found_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
        end
    end

endmodule

// ===== rtl/core/stt_datapath.sv =====
`timescale 1ns / 1ps

module stt_datapath
    import stt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [WORD_W-1:0] in_timeout,
    input  logic [WORD_W-1:0] in_callback,
    input  logic [WORD_W-1:0] in_arg,
    input  logic [SLOT_W-1:0] in_slot,
    input  stt_cmd_t          cmd,
    output stt_status_t       status,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [KIND_W-1:0] out_kind,
    output logic [SLOT_W-1:0] out_slot,
    output logic [WORD_W-1:0] out_callback,
    output logic [WORD_W-1:0] out_arg,
    output logic              out_last
);

    typedef struct packed {
        logic [WORD_W-1:0] deadline;
        logic [WORD_W-1:0] callback;
        logic [WORD_W-1:0] arg;
    } entry_t;

    logic [WORD_W-1:0]     tick_reg;
    logic [NUM_TIMERS-1:0] used_reg;
    logic                  out_valid_reg;

    logic [WORD_W-1:0] req_timeout_reg;
    logic [WORD_W-1:0] req_callback_reg;
    logic [WORD_W-1:0] req_arg_reg;
    logic [SLOT_W-1:0] req_slot_reg;

    entry_t            table_mem [NUM_TIMERS];
    entry_t            rd_reg;

    logic [SLOT_W-1:0] pend_slot_reg;
    logic [WORD_W-1:0] pend_callback_reg;
    logic [WORD_W-1:0] pend_arg_reg;

    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [WORD_W-1:0] callback_reg, callback_next;
    logic [WORD_W-1:0] arg_reg, arg_next;
    logic              last_reg;

    logic              del_in_range;
    logic [IDX_W-1:0]  del_idx;

    assign del_in_range = (int'(req_slot_reg) < NUM_TIMERS);
    assign del_idx      = IDX_W'(req_slot_reg);

    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.create_bad = (req_timeout_reg == '0) || (req_callback_reg == '0);
    assign status.idx_used   = used_reg[cmd.idx];
    assign status.due        = used_reg[cmd.idx] && (rd_reg.deadline <= tick_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.tick_inc)
            begin
                tick_reg <= tick_reg + WORD_W'(1);
            end
            if (cmd.create_wr)
            begin
                used_reg[cmd.idx] <= 1'b1;
            end
            if (cmd.exp_clr)
            begin
                used_reg[cmd.idx] <= 1'b0;
            end
            if (cmd.del_clr && del_in_range)
            begin
                used_reg[del_idx] <= 1'b0;
            end
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // timer table, one port
    always_ff @(posedge clk)
    begin
        if (cmd.create_wr)
        begin
            table_mem[cmd.idx] <= '{deadline: tick_reg + req_timeout_reg,
                                    callback: req_callback_reg,
                                    arg:      req_arg_reg};
        end
        rd_reg <= table_mem[cmd.idx];
    end

    always_comb
    begin
        kind_next     = KIND_FAILED;
        slot_next     = '0;
        callback_next = '0;
        arg_next      = '0;
        case (cmd.push_sel)
            PUSH_CREATED:
            begin
                kind_next = KIND_CREATED;
                slot_next = SLOT_W'(cmd.idx);
            end
            PUSH_FAILED:
            begin
                kind_next = KIND_FAILED;
            end
            PUSH_DELETED:
            begin
                kind_next = KIND_DELETED;
                slot_next = req_slot_reg;
            end
            PUSH_EXPIRED:
            begin
                kind_next     = KIND_EXPIRED;
                slot_next     = pend_slot_reg;
                callback_next = pend_callback_reg;
                arg_next      = pend_arg_reg;
            end
            PUSH_NO_EXPIRY:
            begin
                kind_next = KIND_NO_EXPIRY;
            end
            default:
            begin
                kind_next = KIND_FAILED;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_timeout_reg  <= in_timeout;
            req_callback_reg <= in_callback;
            req_arg_reg      <= in_arg;
            req_slot_reg     <= in_slot;
        end
        if (cmd.pend_load)
        begin
            pend_slot_reg     <= SLOT_W'(cmd.idx);
            pend_callback_reg <= rd_reg.callback;
            pend_arg_reg      <= rd_reg.arg;
        end
        if (cmd.push)
        begin
            kind_reg     <= kind_next;
            slot_reg     <= slot_next;
            callback_reg <= callback_next;
            arg_reg      <= arg_next;
            last_reg     <= cmd.push_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_kind     = kind_reg;
    assign out_slot     = slot_reg;
    assign out_callback = callback_reg;
    assign out_arg      = arg_reg;
    assign out_last     = last_reg;

endmodule

// ===== rtl/core/software_timer_table.sv =====
// one request at a time; the next is taken once the last beat is loaded
// create cost is set by the free-slot scan, tick cost by the read and check of each table entry
// output stalls add cycles; a tick gives at most 8 expiry beats
// reset: asynchronous active low, clears tick count, slot used bits and output valid
// table contents are not cleared; an entry is read only after it was written
`timescale 1ns / 1ps

module software_timer_table
    import stt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,   // timeout, callback_id, arg_value, slot
    input  logic [REQ_W-1:0]    s_axis_tuser,   // req_type
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,   // slot_out, callback_out, arg_out
    output logic [KIND_W-1:0]   m_axis_tuser,   // kind
    output logic                m_axis_tlast
);

    stt_cmd_t          cmd;
    stt_status_t       status;
    logic [KIND_W-1:0] out_kind;
    logic [SLOT_W-1:0] out_slot;
    logic [WORD_W-1:0] out_callback;
    logic [WORD_W-1:0] out_arg;

    stt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_req   (s_axis_tuser),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    stt_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_timeout   (s_axis_tdata[WORD_W-1:0]),
        .in_callback  (s_axis_tdata[2*WORD_W-1:WORD_W]),
        .in_arg       (s_axis_tdata[3*WORD_W-1:2*WORD_W]),
        .in_slot      (s_axis_tdata[3*WORD_W+SLOT_W-1:3*WORD_W]),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_kind     (out_kind),
        .out_slot     (out_slot),
        .out_callback (out_callback),
        .out_arg      (out_arg),
        .out_last     (m_axis_tlast)
    );

    assign m_axis_tuser = out_kind;
    assign m_axis_tdata = M_DATA_W'({out_arg, out_callback, out_slot});

endmodule

// ===== rtl/core/stt_checker.sv =====
`timescale 1ns / 1ps

module stt_checker
    import stt_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic [S_DATA_W-1:0] s_axis_tdata,
    input logic [REQ_W-1:0]    s_axis_tuser,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [M_DATA_W-1:0] m_axis_tdata,
    input logic [KIND_W-1:0]   m_axis_tuser,
    input logic                m_axis_tlast
);

    // a stalled beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
    else $error("stalled result beat changed");

    // a valid request closes the input until its results are out
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready
            && (s_axis_tuser == REQ_CREATE || s_axis_tuser == REQ_DELETE
                || s_axis_tuser == REQ_TICK)
        |=> !s_axis_tready)
    else $error("request taken while another is in work");

    // only expiry beats continue a run
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_EXPIRED |-> m_axis_tlast)
    else $error("non-expiry beat without last");

    // callback and argument are zero except on expiry
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_EXPIRED
        |-> m_axis_tdata[M_DATA_W-1:SLOT_W] == '0)
    else $error("callback or argument set on non-expiry beat");

    // no request is taken while results are still due out
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("request taken in the middle of a result run");

endmodule

bind software_timer_table stt_checker u_stt_checker (.*);
